>>> design/saw_pkg.sv
package saw_pkg;

  localparam int unsigned SEQ_W           = 32;
  localparam int unsigned MASK_OUT_W      = 32;
  localparam int unsigned WINDOW_BITS_DEF = 32;

  typedef logic [SEQ_W-1:0]      seq_t;
  typedef logic [MASK_OUT_W-1:0] mask_out_t;

endpackage

>>> design/saw_update.sv
module saw_update import saw_pkg::*; #(
  parameter int unsigned WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  seq_t                   seq_num,
  input  seq_t                   newest_cur,
  input  logic [WINDOW_BITS-1:0] mask_cur,
  output seq_t                   newest_nxt,
  output logic [WINDOW_BITS-1:0] mask_nxt
);

  localparam int unsigned IDX_W = $clog2(WINDOW_BITS);
  localparam seq_t        WIN   = SEQ_W'(WINDOW_BITS);

  seq_t             diff_up;
  seq_t             diff_dn;
  seq_t             diff_up_m1;
  seq_t             diff_dn_m1;
  logic [IDX_W-1:0] shift_amt;
  logic [IDX_W-1:0] up_bit;
  logic [IDX_W-1:0] dn_bit;

  assign diff_up    = seq_num - newest_cur;
  assign diff_dn    = newest_cur - seq_num;
  assign diff_up_m1 = diff_up - SEQ_W'(1);
  assign diff_dn_m1 = diff_dn - SEQ_W'(1);
  assign shift_amt  = diff_up[IDX_W-1:0];
  assign up_bit     = diff_up_m1[IDX_W-1:0];
  assign dn_bit     = diff_dn_m1[IDX_W-1:0];

  always_comb begin
    newest_nxt = newest_cur;
    mask_nxt   = mask_cur;
    if (seq_num != '0) begin
      if (newest_cur == '0) begin
        newest_nxt = seq_num;
        mask_nxt   = '0;
      end else if (seq_num > newest_cur) begin
        newest_nxt = seq_num;
        if (diff_up >= WIN) begin
          mask_nxt = '0;
        end else begin
          // shift window up and mark the old newest
          mask_nxt = (mask_cur << shift_amt) | (WINDOW_BITS'(1) << up_bit);
        end
      end else if (diff_dn != '0 && diff_dn <= WIN) begin
        mask_nxt = mask_cur | (WINDOW_BITS'(1) << dn_bit);
      end
    end
  end

endmodule

>>> design/seq_ack_window_tracker.sv
// Stages: an accepted input passes the input register, then the result register.
// Throughput: one item per cycle unless out_ready stalls the result; the window update is a
// single compare, subtract and shift between the input register and the result register.
// Reset: synchronous, active low; clears the newest number, the window mask and both
// valid flags. No clearing pass is needed.
module seq_ack_window_tracker import saw_pkg::*; #(
  parameter int unsigned WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  seq_t      in_seq_num,
  output logic      out_valid,
  input  logic      out_ready,
  output seq_t      out_newest_seq,
  output mask_out_t out_ack_mask
);

  logic                   s1_valid_r;
  seq_t                   s1_seq_r;
  logic                   out_valid_r;
  seq_t                   out_newest_r;
  mask_out_t              out_mask_r;
  seq_t                   newest_r;
  logic [WINDOW_BITS-1:0] mask_r;
  seq_t                   newest_nxt;
  logic [WINDOW_BITS-1:0] mask_nxt;
  logic                   s1_adv;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  saw_update #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_update (
    .seq_num    (s1_seq_r),
    .newest_cur (newest_r),
    .mask_cur   (mask_r),
    .newest_nxt (newest_nxt),
    .mask_nxt   (mask_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      newest_r    <= '0;
      mask_r      <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        newest_r    <= newest_nxt;
        mask_r      <= mask_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_seq_r <= in_seq_num;
    end
    if (s1_adv) begin
      out_newest_r <= newest_nxt;
      out_mask_r   <= MASK_OUT_W'(mask_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_newest_seq = out_newest_r;
  assign out_ack_mask   = out_mask_r;

`ifndef ASSERT_OFF
  a_newest_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> newest_r >= $past(newest_r))
    else $error("newest sequence number decreased");

  a_empty_mask_clear: assert property (@(posedge clk) disable iff (!rst_n)
    newest_r == '0 |-> mask_r == '0)
    else $error("window mask set while no newest number");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && s1_valid_r) |-> s1_adv)
    else $error("input register overwritten before it advanced");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_newest_r))
    else $error("stalled result dropped or changed");
`endif

endmodule
